[hdl/sorted_insert_two_way_merge_unit_macros.svh]
// Assertion helpers for the sorted insert / merge unit.
`ifndef SORTED_INSERT_TWO_WAY_MERGE_UNIT_MACROS_SVH
`define SORTED_INSERT_TWO_WAY_MERGE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SITWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitwm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SITWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitwm: next-cycle check failed");

`endif

[hdl/sitwm_pkg.sv]
`default_nettype none

package sitwm_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [2:0] {
        OP_INS_A  = 3'd0,
        OP_INS_B  = 3'd1,
        OP_EMIT_A = 3'd2,
        OP_EMIT_B = 3'd3,
        OP_EMIT_M = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_INS_DONE,
        ST_EM_RD,
        ST_EM_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // capture the incoming item
        logic rd_ins;       // read entry j-1 of the target store
        logic rd_em;        // read both heads
        logic ins_step;     // move entry j-1 up to j, j--
        logic ins_put;      // write the value at j, bump count
        logic status_load;  // load insert status into output register
        logic em_out;       // load chosen head into output register, advance
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  in_op;
        logic in_full;      // target store of incoming insert is full
        logic in_empty;     // target store of incoming insert is empty
        logic in_none;      // incoming emit has nothing to stream
        logic rd_greater;   // entry j-1 > value
        logic j_is_one;
        logic em_last;      // head being emitted is the final one
        logic out_free;     // output register can take an item
    } sts_t;

endpackage

`default_nettype wire

[hdl/sitwm_ctrl.sv]
`default_nettype none

module sitwm_ctrl
    import sitwm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    case (sts.in_op) inside
                        OP_INS_A, OP_INS_B: begin
                            if (sts.in_full) begin
                                state_next = ST_INS_DONE;
                            end else if (sts.in_empty) begin
                                state_next = ST_INS_PUT;
                            end else begin
                                state_next = ST_INS_RD;
                            end
                        end
                        OP_EMIT_A, OP_EMIT_B, OP_EMIT_M: begin
                            if (!sts.in_none) begin
                                state_next = ST_EM_RD;
                            end
                        end
                        default: state_next = ST_IDLE;  // unused codes dropped
                    endcase
                end
            end
            ST_INS_RD: begin
                cmd.rd_ins = 1'b1;
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (sts.rd_greater) begin
                    cmd.ins_step = 1'b1;
                    state_next   = sts.j_is_one ? ST_INS_PUT : ST_INS_RD;
                end else begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                cmd.ins_put = 1'b1;
                state_next  = ST_INS_DONE;
            end
            ST_INS_DONE: begin
                if (sts.out_free) begin
                    cmd.status_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_EM_RD: begin
                cmd.rd_em  = 1'b1;
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (sts.out_free) begin
                    cmd.em_out = 1'b1;
                    state_next = sts.em_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[hdl/sitwm_dpath.sv]
`default_nettype none

module sitwm_dpath
    import sitwm_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [39:0] s_tdata,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] mem_a [DEPTH];
    logic [VALUE_W-1:0] mem_b [DEPTH];

    logic [CW-1:0] count_a_reg, count_b_reg;
    logic [CW-1:0] j_reg, ia_reg, ib_reg, lim_a_reg, lim_b_reg;
    logic signed [VALUE_W-1:0] val_reg, rd_a_reg, rd_b_reg;
    logic sel_b_reg, full_reg;

    logic out_valid_reg, out_is_data_reg, out_full_reg, out_last_reg;
    logic [VALUE_W-1:0] out_value_reg;

    op_t                       in_op;
    logic signed [VALUE_W-1:0] in_value;
    logic [CW-1:0]             in_cnt, in_lim_a, in_lim_b, jm1, ia_inc, ib_inc;
    logic [IW-1:0]             addr_a, addr_b;
    logic signed [VALUE_W-1:0] rd_sel, wr_data, head;
    logic                      we_a, we_b, a_done, b_done, take_b;

    assign in_op    = op_t'(s_tdata[2:0]);
    assign in_value = s_tdata[34:3];
    assign in_cnt   = (in_op == OP_INS_B) ? count_b_reg : count_a_reg;
    assign in_lim_a = (in_op == OP_EMIT_A || in_op == OP_EMIT_M) ? count_a_reg : '0;
    assign in_lim_b = (in_op == OP_EMIT_B || in_op == OP_EMIT_M) ? count_b_reg : '0;

    assign jm1    = j_reg - CW'(1);
    assign ia_inc = ia_reg + CW'(1);
    assign ib_inc = ib_reg + CW'(1);
    assign addr_a = cmd.rd_ins ? jm1[IW-1:0] : ia_reg[IW-1:0];
    assign addr_b = cmd.rd_ins ? jm1[IW-1:0] : ib_reg[IW-1:0];

    assign rd_sel  = sel_b_reg ? rd_b_reg : rd_a_reg;
    assign wr_data = cmd.ins_put ? val_reg : rd_sel;
    assign we_a    = (cmd.ins_step || cmd.ins_put) && !sel_b_reg;
    assign we_b    = (cmd.ins_step || cmd.ins_put) && sel_b_reg;

    // merge pick: tie goes to B
    assign a_done = (ia_reg == lim_a_reg);
    assign b_done = (ib_reg == lim_b_reg);
    assign take_b = a_done || (!b_done && !(rd_b_reg > rd_a_reg));
    assign head   = take_b ? rd_b_reg : rd_a_reg;

    always_comb begin
        sts.in_op      = in_op;
        sts.in_full    = (in_cnt == CW'(DEPTH));
        sts.in_empty   = (in_cnt == '0);
        sts.in_none    = (in_lim_a == '0) && (in_lim_b == '0);
        sts.rd_greater = (rd_sel > val_reg);
        sts.j_is_one   = (j_reg == CW'(1));
        sts.em_last    = take_b ? ((ib_inc == lim_b_reg) && a_done)
                                : ((ia_inc == lim_a_reg) && b_done);
        sts.out_free   = !out_valid_reg || m_tready;
    end

    // store memories: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[j_reg[IW-1:0]] <= wr_data;
        end
        if (we_b) begin
            mem_b[j_reg[IW-1:0]] <= wr_data;
        end
        if (cmd.rd_ins || cmd.rd_em) begin
            rd_a_reg <= mem_a[addr_a];
            rd_b_reg <= mem_b[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_a_reg <= '0;
            count_b_reg <= '0;
        end else if (cmd.ins_put) begin
            if (sel_b_reg) begin
                count_b_reg <= count_b_reg + CW'(1);
            end else begin
                count_a_reg <= count_a_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            val_reg   <= in_value;
            sel_b_reg <= (in_op == OP_INS_B);
            full_reg  <= (in_cnt == CW'(DEPTH));
            j_reg     <= in_cnt;
            ia_reg    <= '0;
            ib_reg    <= '0;
            lim_a_reg <= in_lim_a;
            lim_b_reg <= in_lim_b;
        end else begin
            if (cmd.ins_step) begin
                j_reg <= jm1;
            end
            if (cmd.em_out) begin
                if (take_b) begin
                    ib_reg <= ib_inc;
                end else begin
                    ia_reg <= ia_inc;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.status_load || cmd.em_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.status_load) begin
            out_is_data_reg <= 1'b0;
            out_value_reg   <= '0;
            out_full_reg    <= full_reg;
            out_last_reg    <= 1'b1;
        end else if (cmd.em_out) begin
            out_is_data_reg <= 1'b1;
            out_value_reg   <= head;
            out_full_reg    <= 1'b0;
            out_last_reg    <= sts.em_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_full_reg, out_value_reg};
    assign m_tuser  = out_is_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[hdl/sorted_insert_two_way_merge_unit.sv]
`default_nettype none
// Two ascending sorted stores, A and B, of DEPTH signed 32-bit values each.
// Operation codes: 0 insert A, 1 insert B, 2 emit A, 3 emit B, 4 emit the
// two-way merge (on equal heads B goes first); codes 5 to 7 are swallowed
// with no result. An insert lands just before the first strictly greater
// entry, so equal values keep arrival order, and returns one status item
// (tuser = 0, tlast = 1, store_full set when the store was full and the
// value dropped). An emit returns the values as data items (tuser = 1)
// with tlast on the final one; an empty emit returns nothing and leaves
// the stores untouched. One item is worked at a time. Each store has a
// single read port with registered data, so an insert walks down from
// the top entry by entry: it reads an entry, then compares it and moves
// it up if it is strictly greater, and at last writes the value and
// returns the status; a dropped insert goes straight to its status.
// An emit takes the item, then per value reads the heads and loads the
// chosen one into the output register; an empty emit or an unused code
// is only taken. An output stall holds back the status and each data
// item. Store contents need no clearing after reset; only the counts reset.

`include "sorted_insert_two_way_merge_unit_macros.svh"

module sorted_insert_two_way_merge_unit
    import sitwm_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [2:0] operation, [34:3] value, rest zero
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] result_value, [32] store_full, rest zero
    output logic             m_tuser,   // [0] is_data
    output logic             m_tlast
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: decides the walk of an insert and the pace of an emit
    sitwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stores, counts, indices, merge compare and output register
    sitwm_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // an accepted insert keeps the input closed in the next cycle
    `SITWM_ASSERT_NEXT(a_ins_busy, aclk, aresetn,
        s_tvalid && s_tready && (s_tdata[2:1] == 2'b00), !s_tready)

    // the output register is never overwritten while it holds an untaken item
    `SITWM_ASSERT_IMP(a_out_no_clobber, aclk, aresetn,
        cmd.status_load || cmd.em_out, sts.out_free)

    // no output load happens while the input side is open
    `SITWM_ASSERT_IMP(a_load_not_idle, aclk, aresetn,
        cmd.status_load || cmd.em_out, !s_tready)

endmodule

`default_nettype wire

[verif/sitwm_checker.sv]
`default_nettype none

// Watches both channels, predicts every result from the accepted input items
// and compares each accepted result, field by field, with the oldest one due.
module sitwm_checker
    import sitwm_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,      // [2:0] operation, [34:3] value
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,      // [31:0] result_value, [32] store_full
    input  wire logic        m_tuser,      // [0] is_data
    input  wire logic        m_tlast,
    output int               errors,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEL_A = 0;
    localparam int SEL_B = 1;

    typedef struct packed {
        logic               is_data;
        logic signed [31:0] value;
        logic               full;
        logic               last;
    } result_t;

    result_t            due_results[$];
    logic signed [31:0] sorted_store [2][DEPTH];
    int                 fill [2];
    int                 err_cnt = 0;

    function automatic void add_due(logic is_data, logic signed [31:0] v, logic full,
                                    logic last);
        result_t r;
        r.is_data = is_data;
        r.value   = v;
        r.full    = full;
        r.last    = last;
        due_results.push_back(r);
    endfunction

    // Walk down from the top, shifting strictly greater entries up, so
    // equal values stay in arrival order.
    function automatic void insert_sorted(int sel, logic signed [31:0] v);
        int i;
        if (fill[sel] >= DEPTH) begin
            add_due(1'b0, '0, 1'b1, 1'b1);
            return;
        end
        i = fill[sel];
        while (i > 0 && sorted_store[sel][i - 1] > v) begin
            sorted_store[sel][i] = sorted_store[sel][i - 1];
            i--;
        end
        sorted_store[sel][i] = v;
        fill[sel]++;
        add_due(1'b0, '0, 1'b0, 1'b1);
    endfunction

    function automatic void stream_store(int sel);
        for (int k = 0; k < fill[sel]; k++)
            add_due(1'b1, sorted_store[sel][k], 1'b0, k == fill[sel] - 1);
    endfunction

    // Two-way merge; on equal heads B goes first.
    function automatic void stream_merged();
        int ia;
        int ib;
        int total;
        logic signed [31:0] v;
        ia = 0;
        ib = 0;
        total = fill[SEL_A] + fill[SEL_B];
        for (int k = 0; k < total; k++) begin
            if (ia >= fill[SEL_A]) begin
                v = sorted_store[SEL_B][ib++];
            end else if (ib >= fill[SEL_B]) begin
                v = sorted_store[SEL_A][ia++];
            end else if (sorted_store[SEL_B][ib] > sorted_store[SEL_A][ia]) begin
                v = sorted_store[SEL_A][ia++];
            end else begin
                v = sorted_store[SEL_B][ib++];
            end
            add_due(1'b1, v, 1'b0, k == total - 1);
        end
    endfunction

    function automatic void predict_sorted_results(logic [39:0] item);
        op_t                op;
        logic signed [31:0] v;
        op = op_t'(item[2:0]);
        v  = item[34:3];
        case (op)
            OP_INS_A:  insert_sorted(SEL_A, v);
            OP_INS_B:  insert_sorted(SEL_B, v);
            OP_EMIT_A: stream_store(SEL_A);
            OP_EMIT_B: stream_store(SEL_B);
            OP_EMIT_M: stream_merged();
            default:   ;
        endcase
    endfunction

    function automatic void flag_field(string field, logic signed [31:0] want,
                                       logic signed [31:0] got);
        err_cnt++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    function automatic void check_result();
        result_t got;
        result_t want;
        got = {m_tuser, m_tdata[31:0], m_tdata[32], m_tlast};
        if (due_results.size() == 0) begin
            err_cnt++;
            $display("%0t: result expected none, got is_data %0b value %0d full %0b last %0b",
                     $time, got.is_data, got.value, got.full, got.last);
            return;
        end
        want = due_results.pop_front();
        if (got.is_data !== want.is_data)
            flag_field("is_data", 32'(want.is_data), 32'(got.is_data));
        if (got.value !== want.value)
            flag_field("result_value", want.value, got.value);
        if (got.full !== want.full)
            flag_field("store_full", 32'(want.full), 32'(got.full));
        if (got.last !== want.last)
            flag_field("last", 32'(want.last), 32'(got.last));
    endfunction

    // Results first: a result leaving on the same edge belongs to an older item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            fill[SEL_A] = 0;
            fill[SEL_B] = 0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) predict_sorted_results(s_tdata);
        end
        errors      <= err_cnt;
        outstanding <= due_results.size();
    end

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

// Stimulus and verdict for the sorted insert / two-way merge unit. All
// prediction and comparison live in sitwm_checker.
module tb
    import sitwm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 415;   // plus the directed items, about 430
    localparam int MID_PAUSE_AT = 200;   // random item at which the sender drains
    localparam int MAX_GAP      = 19;    // per-item idle cycles, either side
    localparam int SETTLE       = 100;   // settling wait at the end of a drain
    localparam int HOLD_AFTER   = 150;   // results taken before the long hold
    localparam int LONG_HOLD    = 300;
    localparam int WATCHDOG     = 5000;  // cycles with no item moving
    localparam int OP_LIMIT     = 7;     // highest code the 3-bit field carries

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;           // [2:0] operation, [34:3] value, rest zero
    logic        m_tready = 1'b0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [39:0] m_tdata;            // [31:0] result_value, [32] store_full
    wire logic        m_tuser;            // [0] is_data
    wire logic        m_tlast;

    int errors;
    int outstanding;
    int idle_cycles = 0;
    int tx_quiet    = 0;                  // items left in a no-gap burst

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    sorted_insert_two_way_merge_unit #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sitwm_checker #(.DEPTH(DEPTH)) u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Offer one item after a random gap and hold it until taken. Returns at
    // the accepting edge with s_tvalid still high; the next call either keeps
    // it high (no gap) or drops it, never both in one step.
    task automatic send_item(input logic [2:0] op, input logic [31:0] val);
        int gap;
        if (tx_quiet > 0) begin
            gap = 0;
            tx_quiet--;
        end else begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 9) == 0) tx_quiet = $urandom_range(5, 25);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, val, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait for every due result, then for the block to
    // finish any item that gives no result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mix of extremes, a narrow band around zero (lots of ties), and full range.
    function automatic logic [31:0] draw_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7fff_ffff;
                    1:       v = 32'h8000_0000;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            1:       v = $urandom_range(0, 8) - 4;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Sender: directed part, then random traffic.
    initial begin
        int         issued;
        int         pick;
        bit         mid_pause_done;
        logic [2:0] op;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty stores: every emit gives nothing.
        send_item(OP_EMIT_A, 32'h0);
        send_item(OP_EMIT_B, 32'hffff_ffff);
        send_item(OP_EMIT_M, 32'h0);
        // Unused codes are swallowed.
        for (int c = int'(OP_EMIT_M) + 1; c <= OP_LIMIT; c++)
            send_item(3'(c), 32'hffff_ffff);
        // Extremes into A, with a repeated zero to check arrival order.
        send_item(OP_INS_A, 32'h7fff_ffff);
        send_item(OP_INS_A, 32'h8000_0000);
        send_item(OP_INS_A, 32'h0);
        send_item(OP_INS_A, 32'hffff_ffff);
        send_item(OP_INS_A, 32'h0);
        // B gets a zero too, so the merge sees equal heads.
        send_item(OP_INS_B, 32'h0);
        send_item(OP_INS_B, 32'h8000_0000);
        send_item(OP_INS_B, 32'h7fff_ffff);
        send_item(OP_EMIT_A, 32'h0);
        send_item(OP_EMIT_B, 32'h0);
        send_item(OP_EMIT_M, 32'h0);
        drain();

        // Random part. Stores only grow, so inserts soon start bouncing off
        // full stores and merges run at the full 2*DEPTH length.
        issued         = 0;
        mid_pause_done = 0;
        while (issued < RANDOM_ITEMS) begin
            if (!mid_pause_done && issued == MID_PAUSE_AT) begin
                mid_pause_done = 1;
                drain();
            end
            pick = $urandom_range(0, 99);
            if (pick < 22)      op = OP_INS_A;
            else if (pick < 44) op = OP_INS_B;
            else if (pick < 58) op = OP_EMIT_A;
            else if (pick < 72) op = OP_EMIT_B;
            else if (pick < 92) op = OP_EMIT_M;
            else                op = 3'($urandom_range(int'(OP_EMIT_M) + 1, OP_LIMIT));
            send_item(op, draw_value());
            issued++;
        end

        drain();
        if (errors == 0 && outstanding == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Receiver: random stall per result, no-stall bursts, and one long
    // hold-off while the sender keeps offering, so the block backs up.
    initial begin
        int stall;
        int taken;
        int rx_quiet;
        bit held;
        taken    = 0;
        rx_quiet = 0;
        held     = 0;
        forever begin
            if (rx_quiet > 0) begin
                stall = 0;
                rx_quiet--;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 9) == 0) rx_quiet = $urandom_range(5, 30);
            end
            if (!held && taken >= HOLD_AFTER) begin
                held  = 1;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Watchdog: too long with no item moving on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
